// ===== src/bifr_pkg.sv =====
// Package for the bilevel frame invert/flip/rotate block.
// Holds the payload and config types, the queue entry and shared codes.
// No dependencies.
package bifr_pkg;

	// Width of the size registers and of the read counters
	localparam int SIZE_W = 7;
	// Reset frame size and default store bounds
	localparam logic [SIZE_W-1:0] RST_SIZE = 7'd64;
	localparam int DEF_MAX_WIDTH  = 64;
	localparam int DEF_MAX_HEIGHT = 64;

	// Front-to-back queue
	localparam int QDEPTH = 4;
	localparam int QPW    = 2;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 7;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INVERT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MIRROR = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ROTATE = 3'd4;

	// Item function codes
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_READ = 1'b1;

	typedef struct packed {
		logic func;
		logic pixel_in;
	} in_item_t;

	typedef struct packed {
		logic pixel_out;
		logic row_end;
		logic frame_end;
	} out_item_t;

	// Clamped geometry and enables, as seen by front and back
	typedef struct packed {
		logic [SIZE_W-1:0] width;
		logic [SIZE_W-1:0] height;
		logic              invert;
		logic              mirror;
		logic              rotate;
	} geom_t;

	// One classified item on its way to the back end
	typedef struct packed {
		logic              is_load;
		logic              bit_val;   // pixel for a load, invert flag for a read
		logic              zero;      // read falls outside the store
		logic              row_end;
		logic              frame_end;
		logic [SIZE_W-1:0] row;       // source row of a read
		logic [SIZE_W-1:0] col;       // source column of a read
	} qent_t;

endpackage

// ===== src/bifr_front.sv =====
// Front end: accepts items, drops loads past the frame, walks the output
// raster and maps each read to a source pixel. Uses bifr_pkg.
module bifr_front #(
	parameter int MAX_WIDTH  = bifr_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = bifr_pkg::DEF_MAX_HEIGHT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  bifr_pkg::geom_t   geom,
	input  logic              in_valid,
	output logic              in_ready,
	input  bifr_pkg::in_item_t in_data,
	output logic              push_valid,
	input  logic              push_ready,
	output bifr_pkg::qent_t   push_data
);
	import bifr_pkg::*;

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int LCW   = $clog2(DEPTH + 1);
	localparam int CW    = (LCW > 2 * SIZE_W) ? LCW : 2 * SIZE_W;

	logic [LCW-1:0]    load_count_q;
	logic [SIZE_W-1:0] read_row_q;
	logic [SIZE_W-1:0] read_col_q;

	logic              accept;
	logic              load_ok;
	logic [2*SIZE_W-1:0] frame_size;
	logic [SIZE_W-1:0] out_cols, out_rows;
	logic [SIZE_W-1:0] src_row, src_col, rot_col;
	logic              rend, fend;

	assign in_ready = push_ready;
	assign accept   = in_valid && in_ready;

	// Load admission against the frame size
	assign frame_size = (2*SIZE_W)'(geom.width) * (2*SIZE_W)'(geom.height);
	assign load_ok    = CW'(load_count_q) < CW'(frame_size);

	// Output raster to source pixel
	always_comb begin
		if (geom.rotate) begin
			out_cols = geom.height;
			out_rows = geom.width;
			src_row  = read_col_q;
			rot_col  = (read_row_q < geom.width) ? (geom.width - 1'b1 - read_row_q) : '0;
		end else begin
			out_cols = geom.width;
			out_rows = geom.height;
			src_row  = read_row_q;
			rot_col  = read_col_q;
		end
		if (geom.mirror)
			src_col = (rot_col < geom.width) ? (geom.width - 1'b1 - rot_col) : '0;
		else
			src_col = rot_col;
		rend = read_col_q >= (out_cols - 1'b1);
		fend = rend && (read_row_q >= (out_rows - 1'b1));
	end

	// Queue entry
	always_comb begin
		push_data.is_load   = (in_data.func == FUNC_LOAD);
		push_data.bit_val   = (in_data.func == FUNC_LOAD) ? in_data.pixel_in : geom.invert;
		push_data.zero      = (int'(src_row) >= MAX_HEIGHT) || (src_col >= geom.width);
		push_data.row_end   = rend;
		push_data.frame_end = fend;
		push_data.row       = src_row;
		push_data.col       = src_col;
		push_valid = accept && ((in_data.func == FUNC_READ) || load_ok);
	end

	// Load count and read raster counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_count_q <= '0;
			read_row_q   <= '0;
			read_col_q   <= '0;
		end else if (accept) begin
			if (in_data.func == FUNC_LOAD) begin
				if (load_ok)
					load_count_q <= load_count_q + 1'b1;
			end else if (fend) begin
				load_count_q <= '0;
				read_row_q   <= '0;
				read_col_q   <= '0;
			end else if (rend) begin
				read_col_q <= '0;
				read_row_q <= read_row_q + 1'b1;
			end else begin
				read_col_q <= read_col_q + 1'b1;
			end
		end
	end

endmodule

// ===== src/bifr_queue.sv =====
// Short FIFO of classified items between front and back end.
// Uses bifr_pkg for the entry type and depth.
module bifr_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  bifr_pkg::qent_t push_data,
	output logic            pop_valid,
	input  logic            pop_ready,
	output bifr_pkg::qent_t pop_data
);
	import bifr_pkg::*;

	qent_t          slot_q [QDEPTH];
	logic [QPW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPW:0]   count_q;
	logic           do_push, do_pop;

	assign push_ready = (count_q != (QPW+1)'(QDEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_ptr_q] <= push_data;
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

// ===== src/bifr_back.sv =====
// Back end: address generation, frame store access and result register.
// Uses bifr_pkg; stage 1 forms the address, stage 2 holds the read result.
module bifr_back #(
	parameter int MAX_WIDTH  = bifr_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = bifr_pkg::DEF_MAX_HEIGHT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  bifr_pkg::geom_t     geom,
	input  logic                pop_valid,
	output logic                pop_ready,
	input  bifr_pkg::qent_t     pop_data,
	output logic                out_valid,
	input  logic                out_ready,
	output bifr_pkg::out_item_t out_data
);
	import bifr_pkg::*;

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int PW    = 2 * SIZE_W + 1;

	logic          frame_mem [DEPTH];

	logic [AW-1:0] wr_addr_q;
	logic          v_s1, v_s2;
	qent_t         ent_s1;
	logic [AW-1:0] addr_s1;
	logic          rd_s2, bit_s2, zero_s2, rend_s2, fend_s2;

	logic          adv2, do_pop;
	logic [PW-1:0] rd_lin;

	assign adv2      = !v_s2 || out_ready;
	assign pop_ready = !v_s1 || adv2;
	assign do_pop    = pop_valid && pop_ready;

	// Raster address of a read: row * width + column
	assign rd_lin = PW'(pop_data.row) * PW'(geom.width) + PW'(pop_data.col);

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (do_pop) begin
			ent_s1  <= pop_data;
			addr_s1 <= pop_data.is_load ? wr_addr_q : AW'(rd_lin);
		end
	end

	// Frame store and stage 2 payload
	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			if (ent_s1.is_load) begin
				frame_mem[addr_s1] <= ent_s1.bit_val;
			end else begin
				rd_s2   <= frame_mem[addr_s1];
				bit_s2  <= ent_s1.bit_val;
				zero_s2 <= ent_s1.zero;
				rend_s2 <= ent_s1.row_end;
				fend_s2 <= ent_s1.frame_end;
			end
		end
	end

	// Stage valids and the load address, which restarts with each frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			wr_addr_q <= '0;
		end else begin
			if (pop_ready)
				v_s1 <= pop_valid;
			if (adv2)
				v_s2 <= v_s1 && !ent_s1.is_load;
			if (do_pop) begin
				if (pop_data.is_load)
					wr_addr_q <= wr_addr_q + 1'b1;
				else if (pop_data.frame_end)
					wr_addr_q <= '0;
			end
		end
	end

	assign out_valid          = v_s2;
	assign out_data.pixel_out = (zero_s2 ? 1'b0 : rd_s2) ^ bit_s2;
	assign out_data.row_end   = rend_s2;
	assign out_data.frame_end = fend_s2;

endmodule

// ===== src/bilevel_image_invert_flip_rotate.sv =====
// Top level of the bilevel frame invert/flip/rotate block.
// Holds the config registers; instantiates bifr_front, bifr_queue, bifr_back.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------
//  in      | input     | in_valid / in_ready  | in_data: func, pixel_in
//  out     | output    | out_valid / out_ready| out_data: pixel_out, row_end,
//          |           |                      |           frame_end
//  cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One item per cycle sustained unless out stalls; the single-port frame store
// takes one load or one read each cycle. A read beat lands in the queue, then
// its address is registered, then the store is read into the result
// register, where the result is valid. Loads give no result.
// The frame store has no reset; counters and config reset asynchronously.
// A stall on out backs up the back end, then the queue, then in_ready.
module bilevel_image_invert_flip_rotate #(
	parameter int MAX_WIDTH  = bifr_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = bifr_pkg::DEF_MAX_HEIGHT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  bifr_pkg::in_item_t              in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output bifr_pkg::out_item_t             out_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [bifr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bifr_pkg::CFG_DATA_W-1:0] cfg_data
);
	import bifr_pkg::*;

	logic [SIZE_W-1:0] width_q, height_q;
	logic              invert_q, mirror_q, rotate_q;
	geom_t             geom;

	logic  q_push_valid, q_push_ready, q_pop_valid, q_pop_ready;
	qent_t q_push_data, q_pop_data;

	assign cfg_ready = 1'b1;

	// Config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RST_SIZE;
			height_q <= RST_SIZE;
			invert_q <= 1'b0;
			mirror_q <= 1'b0;
			rotate_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data[SIZE_W-1:0];
				REG_HEIGHT: height_q <= cfg_data[SIZE_W-1:0];
				REG_INVERT: invert_q <= cfg_data[0];
				REG_MIRROR: mirror_q <= cfg_data[0];
				REG_ROTATE: rotate_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Sizes saturated to 1..max
	always_comb begin
		if (width_q == '0)
			geom.width = SIZE_W'(1);
		else if (int'(width_q) > MAX_WIDTH)
			geom.width = SIZE_W'(MAX_WIDTH);
		else
			geom.width = width_q;
		if (height_q == '0)
			geom.height = SIZE_W'(1);
		else if (int'(height_q) > MAX_HEIGHT)
			geom.height = SIZE_W'(MAX_HEIGHT);
		else
			geom.height = height_q;
		geom.invert = invert_q;
		geom.mirror = mirror_q;
		geom.rotate = rotate_q;
	end

	bifr_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.geom      (geom),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.push_valid(q_push_valid),
		.push_ready(q_push_ready),
		.push_data (q_push_data)
	);

	bifr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(q_push_valid),
		.push_ready(q_push_ready),
		.push_data (q_push_data),
		.pop_valid (q_pop_valid),
		.pop_ready (q_pop_ready),
		.pop_data  (q_pop_data)
	);

	bifr_back #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.geom     (geom),
		.pop_valid(q_pop_valid),
		.pop_ready(q_pop_ready),
		.pop_data (q_pop_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	// A read beat always reaches the queue
	a_read_queued: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_data.func == FUNC_READ) |-> q_push_valid)
		else $error("read beat not queued");

	// Queue pushes only come from accepted beats
	a_push_from_beat: assert property (@(posedge clk) disable iff (!arst_n)
		q_push_valid |-> in_valid && in_ready)
		else $error("queue push without input beat");

	// Frame end is always also a row end
	a_frame_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.frame_end |-> out_data.row_end)
		else $error("frame end without row end");

endmodule

// ===== sim/bifr_checker.sv =====
// Scoreboard for the bilevel frame invert/flip/rotate block: watches all three channels,
// predicts each read result from its own copy of the frame and registers, and compares.
// Depends on bifr_pkg only.
`timescale 1ns / 100ps
module bifr_checker #(
	parameter int MAX_W = bifr_pkg::DEF_MAX_WIDTH,
	parameter int MAX_H = bifr_pkg::DEF_MAX_HEIGHT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  bifr_pkg::in_item_t              in_data,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  bifr_pkg::out_item_t             out_data,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [bifr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bifr_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            run_done,
	output int                              fails,
	output int                              pending,
	output int                              checked
);
	import bifr_pkg::*;

	localparam int STORE_BITS = MAX_W * MAX_H;
	localparam int PRINT_CAP  = 40;

	// Shadow frame, counters and registers
	logic                  frame_bits [STORE_BITS];
	int unsigned           fill_ptr;
	int unsigned           out_row;
	int unsigned           out_col;
	logic [CFG_DATA_W-1:0] width_reg;
	logic [CFG_DATA_W-1:0] height_reg;
	logic                  invert_on;
	logic                  mirror_on;
	logic                  rotate_on;
	out_item_t             expected_pixels [$];
	bit                    leftovers_checked;

	initial begin
		fails = 0;
		pending = 0;
		checked = 0;
		leftovers_checked = 1'b0;
		foreach (frame_bits[i]) frame_bits[i] = 1'b0;
	end

	task automatic report_mismatch(input string what);
		if (fails < PRINT_CAP) $display("%0t: pixel stream mismatch: %s", $time, what);
		fails++;
	endtask

	// Size registers saturate to 1..limit
	function automatic int unsigned clamp_dim(input logic [CFG_DATA_W-1:0] v,
			input int unsigned lim);
		if (v == '0) return 1;
		if (v > lim) return lim;
		return v;
	endfunction

	task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_WIDTH:  width_reg = data;
			REG_HEIGHT: height_reg = data;
			REG_INVERT: invert_on = data[0];
			REG_MIRROR: mirror_on = data[0];
			REG_ROTATE: rotate_on = data[0];
			default: ;
		endcase
	endtask

	// Loads fill the frame in raster order; reads produce one transformed pixel
	task automatic step_frame(input in_item_t item);
		int unsigned w, h, cols, rows, src_row, src_col;
		logic        stored;
		out_item_t   res;
		w = clamp_dim(width_reg, MAX_W);
		h = clamp_dim(height_reg, MAX_H);
		if (item.func == FUNC_LOAD) begin
			if (fill_ptr < w * h && fill_ptr < STORE_BITS) begin
				frame_bits[fill_ptr] = item.pixel_in;
				fill_ptr++;
			end
			return;
		end
		if (rotate_on) begin
			cols = h;
			rows = w;
			src_row = out_col;
			src_col = (out_row < w) ? w - 1 - out_row : 0;
		end else begin
			cols = w;
			rows = h;
			src_row = out_row;
			src_col = out_col;
		end
		if (mirror_on)
			src_col = (src_col < w) ? w - 1 - src_col : 0;
		// source pixels outside the store read as zero
		if (src_row >= MAX_H || src_col >= w)
			stored = 1'b0;
		else
			stored = frame_bits[src_row * w + src_col];
		res.pixel_out = stored ^ invert_on;
		res.row_end   = (out_col >= cols - 1);
		res.frame_end = res.row_end && (out_row >= rows - 1);
		if (res.frame_end) begin
			out_row = 0;
			out_col = 0;
			fill_ptr = 0;
		end else if (res.row_end) begin
			out_col = 0;
			out_row++;
		end else begin
			out_col++;
		end
		expected_pixels.push_back(res);
	endtask

	task automatic compare_result(input out_item_t got);
		out_item_t want;
		if (expected_pixels.size() == 0) begin
			report_mismatch("output beat with no read outstanding");
			return;
		end
		want = expected_pixels.pop_front();
		checked++;
		if (got.pixel_out !== want.pixel_out)
			report_mismatch($sformatf("beat %0d pixel_out %b, want %b",
				checked, got.pixel_out, want.pixel_out));
		if (got.row_end !== want.row_end)
			report_mismatch($sformatf("beat %0d row_end %b, want %b",
				checked, got.row_end, want.row_end));
		if (got.frame_end !== want.frame_end)
			report_mismatch($sformatf("beat %0d frame_end %b, want %b",
				checked, got.frame_end, want.frame_end));
	endtask

	// Sample all channels at the rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_ptr = 0;
			out_row = 0;
			out_col = 0;
			width_reg = RST_SIZE;
			height_reg = RST_SIZE;
			invert_on = 1'b0;
			mirror_on = 1'b0;
			rotate_on = 1'b0;
			expected_pixels.delete();
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
			if (in_valid && in_ready) step_frame(in_data);
			if (out_valid && out_ready) compare_result(out_data);
			if (run_done && !leftovers_checked) begin
				leftovers_checked = 1'b1;
				if (expected_pixels.size() != 0)
					report_mismatch($sformatf("%0d expected results never arrived",
						expected_pixels.size()));
			end
			pending = expected_pixels.size();
		end
	end

endmodule

// ===== sim/bilevel_image_invert_flip_rotate_tb.sv =====
// Testbench top for bilevel_image_invert_flip_rotate: clock, reset, stimulus and verdict.
// Drives the pixel and register channels and the result back-pressure; bifr_checker checks.
// Depends on bifr_pkg, bifr_checker and the block's RTL.
`timescale 1ns / 100ps
module bilevel_image_invert_flip_rotate_tb;
	import bifr_pkg::*;

	localparam int MAX_W         = DEF_MAX_WIDTH;
	localparam int MAX_H         = DEF_MAX_HEIGHT;
	localparam int CLK_HALF      = 5;
	localparam int IDLE_PCT      = 26;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES   = 200;
	localparam int DRAIN_LIMIT   = 20000;
	localparam int ITEM_GOAL     = 1200;
	localparam int QUIET_FROM    = 300;
	localparam int QUIET_TO      = 600;
	localparam int MAX_FRAME_PX  = 128;
	localparam longint TIMEOUT_NS = 2_000_000;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	in_item_t              in_data;
	logic                  out_valid;
	logic                  out_ready;
	out_item_t             out_data;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  run_done;
	int                    fails;
	int                    pending;
	int                    checked;

	// Stimulus bookkeeping
	bit          quiet = 1'b0;
	bit          hold_req = 1'b0;
	int unsigned cur_w = MAX_W;
	int unsigned cur_h = MAX_H;
	int unsigned rd_pos = 0;       // reads since the current output frame began
	int          load_beats = 0;
	int          read_beats = 0;
	int          reg_writes = 0;
	int          setups = 0;

	always #(CLK_HALF) clk = ~clk;

	bilevel_image_invert_flip_rotate dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	bifr_checker pixel_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.run_done  (run_done),
		.fails     (fails),
		.pending   (pending),
		.checked   (checked)
	);

	function automatic int unsigned eff_dim(input logic [CFG_DATA_W-1:0] v, input int unsigned lim);
		if (v == '0) return 1;
		if (v > lim) return lim;
		return v;
	endfunction

	// Mostly small frames, with the edges of the 7-bit size field now and then
	function automatic logic [CFG_DATA_W-1:0] pick_dim();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 65) return CFG_DATA_W'($urandom_range(1, 6));
		if (r < 75) return CFG_DATA_W'($urandom_range(7, 12));
		if (r < 82) return CFG_DATA_W'(1);
		if (r < 88) return CFG_DATA_W'(MAX_W);
		if (r < 93) return '0;
		return CFG_DATA_W'($urandom_range(65, 127));
	endfunction

	// One pixel beat; valid holds until accepted
	task automatic send_beat(input logic func, input logic pix);
		in_item_t item;
		item.func = func;
		item.pixel_in = pix;
		@(negedge clk);
		while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		do @(posedge clk); while (!in_ready);
		if (func == FUNC_LOAD) begin
			load_beats++;
		end else begin
			read_beats++;
			rd_pos++;
			if (rd_pos >= cur_w * cur_h) rd_pos = 0;
		end
	endtask

	task automatic send_loads(input int unsigned n);
		repeat (n) send_beat(FUNC_LOAD, 1'($urandom_range(0, 1)));
	endtask

	task automatic send_reads(input int unsigned n);
		repeat (n) send_beat(FUNC_READ, 1'($urandom_range(0, 1)));
	endtask

	// Read out the rest of the current frame so the raster counters restart
	task automatic close_frame();
		if (rd_pos != 0) send_reads(cur_w * cur_h - rd_pos);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		reg_writes++;
		case (idx)
			REG_WIDTH:  cur_w = eff_dim(data, MAX_W);
			REG_HEIGHT: cur_h = eff_dim(data, MAX_H);
			default: ;
		endcase
	endtask

	// Drop valid, wait for every read result, then let the pipe drain
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic pick_setup(input bit all_regs);
		logic [CFG_DATA_W-1:0] wv, hv;
		settle();
		wv = pick_dim();
		hv = pick_dim();
		if (eff_dim(wv, MAX_W) * eff_dim(hv, MAX_H) > MAX_FRAME_PX)
			hv = CFG_DATA_W'($urandom_range(1, 2));
		write_reg(REG_WIDTH, wv);
		write_reg(REG_HEIGHT, hv);
		if (all_regs || $urandom_range(0, 99) < 70)
			write_reg(REG_INVERT, CFG_DATA_W'($urandom_range(0, 127)));
		if (all_regs || $urandom_range(0, 99) < 70)
			write_reg(REG_MIRROR, CFG_DATA_W'($urandom_range(0, 127)));
		if (all_regs || $urandom_range(0, 99) < 70)
			write_reg(REG_ROTATE, CFG_DATA_W'($urandom_range(0, 127)));
		// unmapped indexes must be harmless
		if ($urandom_range(0, 99) < 10)
			write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
				CFG_DATA_W'($urandom_range(0, 127)));
		setups++;
	endtask

	// Mostly whole frames (load then read back); some partial frames and random mixes,
	// each closed by enough reads to end the output frame
	task automatic random_phase();
		int unsigned frame_px, r, n;
		frame_px = cur_w * cur_h;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			send_loads(frame_px);
			send_reads(frame_px);
		end else if (r < 85) begin
			n = $urandom_range(0, frame_px + 3);
			send_loads(n);
			n = $urandom_range(1, frame_px);
			send_reads(n);
		end else begin
			n = $urandom_range(1, 2 * frame_px);
			repeat (n) send_beat(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		end
		close_frame();
	endtask

	// Result side back-pressure, plus one long hold-off on request
	initial begin
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				for (int n = 0; n < HOLD_CYCLES; n++) @(negedge clk);
			end
			out_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Timeout with %0d results outstanding", pending);
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		run_done = 1'b0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Fill every address a later read can reach; frames stay within MAX_FRAME_PX
		// and the fill pointer stays past the small frames until the next frame end
		send_loads(MAX_FRAME_PX);
		settle();

		// Loads past a full frame are dropped; six reads close a 3x2 frame
		write_reg(REG_WIDTH, 3);
		write_reg(REG_HEIGHT, 2);
		send_beat(FUNC_LOAD, 1'b1);
		send_beat(FUNC_LOAD, 1'b0);
		send_reads(6);
		settle();

		// Width 0 acts as 1; all three steps on; reads interleaved with loads
		write_reg(REG_WIDTH, 0);
		write_reg(REG_HEIGHT, 2);
		write_reg(REG_INVERT, 1);
		write_reg(REG_MIRROR, 1);
		write_reg(REG_ROTATE, 1);
		send_beat(FUNC_LOAD, 1'b1);
		send_beat(FUNC_READ, 1'b0);
		send_beat(FUNC_LOAD, 1'b0);
		send_beat(FUNC_READ, 1'b1);
		settle();

		// Stop mid-frame, then shrink the frame so the counters sit past it
		write_reg(REG_WIDTH, 4);
		write_reg(REG_HEIGHT, 3);
		write_reg(REG_INVERT, 0);
		write_reg(REG_MIRROR, 0);
		send_reads(5);
		settle();
		write_reg(REG_WIDTH, 2);
		write_reg(REG_HEIGHT, 1);
		write_reg(REG_ROTATE, 0);
		send_reads(2);
		// the next read ends the shrunken frame
		send_reads(1);
		rd_pos = 0;
		settle();

		// Long result stall while reads keep coming, so the input side backs up
		write_reg(REG_WIDTH, 8);
		write_reg(REG_HEIGHT, 8);
		send_loads(64);
		hold_req = 1'b1;
		send_reads(64);

		// Random frames; one stretch runs with no idling on either side
		while (load_beats + read_beats < ITEM_GOAL) begin
			quiet = (load_beats + read_beats >= QUIET_FROM &&
				load_beats + read_beats < QUIET_TO);
			pick_setup(setups == 0);
			random_phase();
		end
		quiet = 1'b0;

		@(negedge clk);
		in_valid <= 1'b0;
		for (int n = 0; n < DRAIN_LIMIT && pending != 0; n++) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		run_done = 1'b1;
		@(posedge clk);
		@(negedge clk);

		$display("Run covered %0d loads and %0d reads over %0d random frame setups,",
			load_beats, read_beats, setups);
		$display("with %0d register writes and %0d output beats checked", reg_writes, checked);
		if (fails == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/bifr_pkg.sv
src/bifr_front.sv
src/bifr_queue.sv
src/bifr_back.sv
src/bilevel_image_invert_flip_rotate.sv
sim/bifr_checker.sv
sim/bilevel_image_invert_flip_rotate_tb.sv
